### hw/rtl/cids_pkg.sv
// Shared types, character codes, dispatch and keyword_step of the include scanner.
`default_nettype none

package cids_pkg;

    // Character codes the scanner reacts to.
    localparam logic [7:0] C_SLASH     = 8'h2F;
    localparam logic [7:0] C_SQUOTE    = 8'h27;
    localparam logic [7:0] C_DQUOTE    = 8'h22;
    localparam logic [7:0] C_HASH      = 8'h23;
    localparam logic [7:0] C_STAR      = 8'h2A;
    localparam logic [7:0] C_BACKSLASH = 8'h5C;
    localparam logic [7:0] C_TAB       = 8'h09;
    localparam logic [7:0] C_NEWLINE   = 8'h0A;
    localparam logic [7:0] C_SPACE     = 8'h20;
    localparam logic [7:0] C_LOWER_I   = 8'h69;
    localparam logic [7:0] C_LOWER_N   = 8'h6E;
    localparam logic [7:0] C_LOWER_C   = 8'h63;
    localparam logic [7:0] C_LOWER_L   = 8'h6C;
    localparam logic [7:0] C_LOWER_U   = 8'h75;
    localparam logic [7:0] C_LOWER_D   = 8'h64;
    localparam logic [7:0] C_LOWER_E   = 8'h65;

    // Width of the packed result flags carried on tuser.
    localparam int unsigned FLAG_W = 3;

    // Scanner states, one-hot.
    typedef enum logic [16:0] {
        ST_START    = 17'h00001,
        ST_SLASH    = 17'h00002,
        ST_CMT      = 17'h00004,
        ST_CMT_STAR = 17'h00008,
        ST_SQ       = 17'h00010,
        ST_SQ_ESC   = 17'h00020,
        ST_DQ       = 17'h00040,
        ST_DQ_ESC   = 17'h00080,
        ST_POUND    = 17'h00100,
        ST_KW_N     = 17'h00200,
        ST_KW_C     = 17'h00400,
        ST_KW_L     = 17'h00800,
        ST_KW_U     = 17'h01000,
        ST_KW_D     = 17'h02000,
        ST_KW_E     = 17'h04000,
        ST_INCL     = 17'h08000,
        ST_NAME     = 17'h10000
    } t_scan_state;

    // Result flags, lowest bit first: name_valid, name_done, name_abort.
    typedef struct packed {
        logic name_abort;
        logic name_done;
        logic name_valid;
    } t_flags;

    // State entered from start by a byte that may open a comment, literal or directive.
    function automatic t_scan_state dispatch(input logic [7:0] c);
        t_scan_state s;
        case (c)
            C_SLASH:  s = ST_SLASH;
            C_SQUOTE: s = ST_SQ;
            C_DQUOTE: s = ST_DQ;
            C_HASH:   s = ST_POUND;
            default:  s = ST_START;
        endcase
        return s;
    endfunction

    // One letter of the keyword: advance on a match, otherwise rescan the byte.
    function automatic t_scan_state keyword_step(input logic [7:0] c,
                                                 input logic [7:0] want,
                                                 input t_scan_state next);
        t_scan_state s;
        s = (c == want) ? next : dispatch(c);
        return s;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/c_include_directive_scanner.sv
// Top level of the quoted include directive scanner.
`default_nettype none

// Channel   Direction  Item                         Ports
// s         in         one source byte              i_s_tvalid, o_s_tready, i_s_tdata, i_s_tlast
// m         out        one result for that byte     o_m_tvalid, i_m_tready, o_m_tdata, o_m_tuser,
//                                                   o_m_tlast
//
// Every accepted byte yields exactly one result item, in the cycle after it is taken.
// The throughput is one byte per cycle while the output is not stalled; it is set by the
// single state register, updated from the byte and the current state in the same cycle.
// The result register is refilled whenever it is empty or its item is taken in
// that cycle, so a stalled output holds the input back only while it is full.
// Reset (synchronous, active low) puts the scanner in its start state and empties
// the result register.
module c_include_directive_scanner
    import cids_pkg::*;
(
    input  wire              i_clk,
    input  wire              i_rst_n,
    // Source bytes.
    input  wire              i_s_tvalid,
    output logic             o_s_tready,
    input  wire  [7:0]       i_s_tdata,   // [7:0] source_byte
    input  wire              i_s_tlast,   // end_of_file
    // Results.
    output logic             o_m_tvalid,
    input  wire              i_m_tready,
    output logic [7:0]       o_m_tdata,   // [7:0] name_byte
    output logic [FLAG_W-1:0] o_m_tuser,  // [0] name_valid, [1] name_done, [2] name_abort
    output logic             o_m_tlast    // file_done
);

    t_scan_state r_state;
    t_scan_state n_state;
    logic        r_out_valid;
    logic [7:0]  r_name_byte;
    t_flags      r_flags;
    logic        r_file_done;

    logic        s_accept;
    t_scan_state step_state;
    t_flags      n_flags;
    logic [7:0]  n_name_byte;

    // A byte is taken whenever the result register is free or being emptied.
    assign o_s_tready = !r_out_valid || i_m_tready;
    assign s_accept   = i_s_tvalid && o_s_tready;

    // One transition of the scanner. Any byte that breaks a partial match is
    // rescanned from the start state in the same step.
    always_comb begin
        n_flags     = '0;
        n_name_byte = '0;
        case (r_state)
            ST_SLASH: begin
                step_state = (i_s_tdata == C_STAR) ? ST_CMT : dispatch(i_s_tdata);
            end
            ST_CMT: begin
                step_state = (i_s_tdata == C_STAR) ? ST_CMT_STAR : ST_CMT;
            end
            ST_CMT_STAR: begin
                // A run of stars keeps the comment ready to close.
                if (i_s_tdata == C_SLASH) begin
                    step_state = ST_START;
                end else if (i_s_tdata == C_STAR) begin
                    step_state = ST_CMT_STAR;
                end else begin
                    step_state = ST_CMT;
                end
            end
            ST_SQ: begin
                if (i_s_tdata == C_SQUOTE) begin
                    step_state = ST_START;
                end else if (i_s_tdata == C_BACKSLASH) begin
                    step_state = ST_SQ_ESC;
                end else begin
                    step_state = ST_SQ;
                end
            end
            ST_SQ_ESC: begin
                step_state = ST_SQ;
            end
            ST_DQ: begin
                if (i_s_tdata == C_DQUOTE) begin
                    step_state = ST_START;
                end else if (i_s_tdata == C_BACKSLASH) begin
                    step_state = ST_DQ_ESC;
                end else begin
                    step_state = ST_DQ;
                end
            end
            ST_DQ_ESC: begin
                step_state = ST_DQ;
            end
            ST_POUND: begin
                if (i_s_tdata == C_SPACE || i_s_tdata == C_TAB) begin
                    step_state = ST_POUND;
                end else if (i_s_tdata == C_LOWER_I) begin
                    step_state = ST_KW_N;
                end else begin
                    step_state = dispatch(i_s_tdata);
                end
            end
            ST_KW_N: step_state = keyword_step(i_s_tdata, C_LOWER_N, ST_KW_C);
            ST_KW_C: step_state = keyword_step(i_s_tdata, C_LOWER_C, ST_KW_L);
            ST_KW_L: step_state = keyword_step(i_s_tdata, C_LOWER_L, ST_KW_U);
            ST_KW_U: step_state = keyword_step(i_s_tdata, C_LOWER_U, ST_KW_D);
            ST_KW_D: step_state = keyword_step(i_s_tdata, C_LOWER_D, ST_KW_E);
            ST_KW_E: step_state = keyword_step(i_s_tdata, C_LOWER_E, ST_INCL);
            ST_INCL: begin
                if (i_s_tdata == C_SPACE || i_s_tdata == C_TAB) begin
                    step_state = ST_INCL;
                end else if (i_s_tdata == C_DQUOTE) begin
                    step_state = ST_NAME;
                end else begin
                    step_state = dispatch(i_s_tdata);
                end
            end
            ST_NAME: begin
                // A newline cancels the name and is not rescanned.
                if (i_s_tdata == C_NEWLINE) begin
                    n_flags.name_abort = 1'b1;
                    step_state         = ST_START;
                end else if (i_s_tdata == C_DQUOTE) begin
                    n_flags.name_done  = 1'b1;
                    step_state         = ST_START;
                end else begin
                    n_flags.name_valid = 1'b1;
                    n_name_byte        = i_s_tdata;
                    step_state         = ST_NAME;
                end
            end
            default: begin
                step_state = dispatch(i_s_tdata);
            end
        endcase

        // The last byte of a file drops whatever was open; a name left
        // pending at that point is reported as cancelled.
        if (i_s_tlast) begin
            if (step_state == ST_NAME) begin
                n_flags.name_abort = 1'b1;
            end
            n_state = ST_START;
        end else begin
            n_state = step_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_START;
            r_out_valid <= 1'b0;
        end else begin
            if (s_accept) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_name_byte <= n_name_byte;
            r_flags     <= n_flags;
            r_file_done <= i_s_tlast;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_name_byte;
    assign o_m_tuser  = r_flags;
    assign o_m_tlast  = r_file_done;

    // A name is never both completed and cancelled by one byte.
    a_done_abort_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_flags.name_done && r_flags.name_abort))
        else $error("name_done and name_abort both set");

    // The closing quote is not itself a name byte.
    a_valid_not_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_flags.name_valid |-> !r_flags.name_done)
        else $error("name byte flagged on closing quote");

    // Outside a name the byte field reads as zero.
    a_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_flags.name_valid |-> r_name_byte == 8'h00)
        else $error("name_byte nonzero without name_valid");

    // The last byte of a file always returns the scanner to start.
    a_eof_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept && i_s_tlast |=> r_state == ST_START)
        else $error("scanner not in start state after end of file");

endmodule

`default_nettype wire

### tb/c_include_directive_scanner_test.sv
// Self-checking testbench for the quoted include directive scanner.
`timescale 1ns / 1ps

// Source bytes are fed from a queue through a clocked driver. A clocked monitor
// predicts one result for every accepted byte and checks the results as they
// come out. The stimulus is mostly well-formed fragments of C source with random
// content: include directives, block comments, literals and newlines. The rest is
// noise and broken directives. The run goes through three idling phases. It also
// holds off the receiver for a long stretch and pauses the sender until the
// block has drained.
module c_include_directive_scanner_test;
    import cids_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 5000;
    localparam int unsigned DRAIN_CYCLES   = 16;
    localparam int unsigned HOLD_CYCLES    = 60;
    localparam int unsigned MAX_REPORTS    = 10;

    // One source byte and its end of file mark.
    typedef struct {
        logic [7:0] data;
        logic       eof;
    } t_source_item;

    // One result of the scanner, in the order of the result fields.
    typedef struct packed {
        logic [7:0] name_byte;
        logic       name_valid;
        logic       name_done;
        logic       name_abort;
        logic       file_done;
    } t_scan_result;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_s_tvalid = 1'b0;
    logic                o_s_tready;
    logic [7:0]          i_s_tdata = 8'h00;   // [7:0] source_byte
    logic                i_s_tlast = 1'b0;    // end_of_file
    logic                o_m_tvalid;
    logic                i_m_tready = 1'b0;
    logic [7:0]          o_m_tdata;           // [7:0] name_byte
    logic [FLAG_W-1:0]   o_m_tuser;           // [0] name_valid, [1] name_done, [2] name_abort
    logic                o_m_tlast;           // file_done

    t_source_item pending_bytes[$];
    t_scan_result expected_results[$];
    t_scan_state  scanner_state = ST_START;

    int unsigned sender_idle_pct   = 27;
    int unsigned receiver_idle_pct = 87;
    int unsigned bytes_queued      = 0;
    int unsigned bytes_accepted    = 0;
    int unsigned failures          = 0;
    int unsigned hold_requests     = 0;
    int unsigned holds_started     = 0;
    int unsigned hold_left         = 0;
    int unsigned stall_cycles      = 0;

    c_include_directive_scanner DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    always #5 i_clk = ~i_clk;

    // State that a byte leads to when it is scanned from the start state.
    function automatic t_scan_state restart_on(input logic [7:0] c);
        t_scan_state ns;
        if (c == C_SLASH) ns = ST_SLASH;
        else if (c == C_SQUOTE) ns = ST_SQ;
        else if (c == C_DQUOTE) ns = ST_DQ;
        else if (c == C_HASH) ns = ST_POUND;
        else ns = ST_START;
        return ns;
    endfunction

    // Scans one byte: returns its result and gives the next scanner state.
    function automatic t_scan_result scan_byte(input t_scan_state cur, input logic [7:0] c,
                                               input logic eof, output t_scan_state nxt);
        t_scan_result r;
        t_scan_state  ns;
        logic         is_blank;
        r = '0;
        is_blank = (c == C_SPACE) || (c == C_TAB);
        case (cur)
            ST_SLASH:    ns = (c == C_STAR) ? ST_CMT : restart_on(c);
            ST_CMT:      ns = (c == C_STAR) ? ST_CMT_STAR : ST_CMT;
            ST_CMT_STAR: begin
                if (c == C_SLASH) ns = ST_START;
                else if (c == C_STAR) ns = ST_CMT_STAR;
                else ns = ST_CMT;
            end
            ST_SQ: begin
                if (c == C_SQUOTE) ns = ST_START;
                else if (c == C_BACKSLASH) ns = ST_SQ_ESC;
                else ns = ST_SQ;
            end
            ST_SQ_ESC:   ns = ST_SQ;
            ST_DQ: begin
                if (c == C_DQUOTE) ns = ST_START;
                else if (c == C_BACKSLASH) ns = ST_DQ_ESC;
                else ns = ST_DQ;
            end
            ST_DQ_ESC:   ns = ST_DQ;
            ST_POUND: begin
                if (is_blank) ns = ST_POUND;
                else if (c == C_LOWER_I) ns = ST_KW_N;
                else ns = restart_on(c);
            end
            ST_KW_N:     ns = (c == C_LOWER_N) ? ST_KW_C : restart_on(c);
            ST_KW_C:     ns = (c == C_LOWER_C) ? ST_KW_L : restart_on(c);
            ST_KW_L:     ns = (c == C_LOWER_L) ? ST_KW_U : restart_on(c);
            ST_KW_U:     ns = (c == C_LOWER_U) ? ST_KW_D : restart_on(c);
            ST_KW_D:     ns = (c == C_LOWER_D) ? ST_KW_E : restart_on(c);
            ST_KW_E:     ns = (c == C_LOWER_E) ? ST_INCL : restart_on(c);
            ST_INCL: begin
                if (is_blank) ns = ST_INCL;
                else if (c == C_DQUOTE) ns = ST_NAME;
                else ns = restart_on(c);
            end
            ST_NAME: begin
                ns = ST_START;
                if (c == C_NEWLINE) begin
                    r.name_abort = 1'b1;
                end else if (c == C_DQUOTE) begin
                    r.name_done = 1'b1;
                end else begin
                    r.name_valid = 1'b1;
                    r.name_byte  = c;
                    ns = ST_NAME;
                end
            end
            default:     ns = restart_on(c);
        endcase
        // The end of a file cancels a pending name and drops everything else silently.
        if (eof) begin
            if (ns == ST_NAME) r.name_abort = 1'b1;
            ns = ST_START;
        end
        r.file_done = eof;
        nxt = ns;
        return r;
    endfunction

    // Driver: a new item may be offered only when the slot is empty or its item is taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else if (!i_s_tvalid || o_s_tready) begin
            if (pending_bytes.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                i_s_tvalid <= 1'b1;
                i_s_tdata  <= pending_bytes[0].data;
                i_s_tlast  <= pending_bytes[0].eof;
                pending_bytes.pop_front();
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off when one is requested.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            i_m_tready <= 1'b0;
            hold_left  <= hold_left - 1;
        end else if (holds_started != hold_requests) begin
            i_m_tready    <= 1'b0;
            hold_left     <= HOLD_CYCLES;
            holds_started <= holds_started + 1;
        end else begin
            i_m_tready <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    // Monitor: predicts on accepted bytes first, then checks the accepted result,
    // so the order of two handshakes that fall together never matters.
    always @(posedge i_clk) begin
        t_scan_result want;
        t_scan_result got;
        t_flags       flags;
        t_scan_state  nxt;
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) begin
                want = scan_byte(scanner_state, i_s_tdata, i_s_tlast, nxt);
                scanner_state = nxt;
                expected_results.push_back(want);
                bytes_accepted++;
            end
            if (o_m_tvalid && i_m_tready) begin
                flags = o_m_tuser;
                got.name_byte  = o_m_tdata;
                got.name_valid = flags.name_valid;
                got.name_done  = flags.name_done;
                got.name_abort = flags.name_abort;
                got.file_done  = o_m_tlast;
                if (expected_results.size() == 0) begin
                    failures++;
                    if (failures <= MAX_REPORTS)
                        $display("mismatch at %0t: result with none expected, byte %h", $realtime,
                                 got.name_byte);
                end else begin
                    want = expected_results.pop_front();
                    if (got.name_byte !== want.name_byte || got.name_valid !== want.name_valid ||
                        got.name_done !== want.name_done || got.name_abort !== want.name_abort ||
                        got.file_done !== want.file_done) begin
                        failures++;
                        if (failures <= MAX_REPORTS) begin
                            $write("mismatch at %0t: expected byte %h valid %b done %b ",
                                   $realtime, want.name_byte, want.name_valid, want.name_done);
                            $write("abort %b last %b, ", want.name_abort, want.file_done);
                            $display("got byte %h valid %b done %b abort %b last %b",
                                     got.name_byte, got.name_valid, got.name_done,
                                     got.name_abort, got.file_done);
                        end
                    end
                end
            end
        end
    end

    // Watchdog: ends the run when no handshake happens for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles == WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic queue_byte(input logic [7:0] c, input logic eof = 1'b0);
        t_source_item item;
        item.data = c;
        item.eof  = eof;
        pending_bytes.push_back(item);
        bytes_queued++;
    endtask

    task automatic queue_text(input string s);
        for (int i = 0; i < s.len(); i++) queue_byte(s[i]);
    endtask

    // Zero to two spaces or tabs.
    task automatic queue_blanks();
        int n;
        n = $urandom_range(2);
        repeat (n) queue_byte($urandom_range(1) ? C_SPACE : C_TAB);
    endtask

    // One fragment of source text. Most are well formed, and directives let the scanner
    // reach the name state; in a few directives one letter of the keyword gets corrupted.
    task automatic queue_random_fragment();
        string       keyword;
        int          kind;
        int          len;
        int          ending;
        int          broken;
        logic [7:0]  c;
        logic [7:0]  quote;
        keyword = "include";
        kind = $urandom_range(99);
        if (kind < 45) begin
            queue_byte(C_HASH);
            queue_blanks();
            broken = ($urandom_range(7) == 0) ? int'($urandom_range(6)) : -1;
            for (int i = 0; i < 7; i++)
                queue_byte((i == broken) ? 8'($urandom_range(255)) : 8'(keyword[i]));
            queue_blanks();
            queue_byte(C_DQUOTE);
            len = $urandom_range(6);
            for (int i = 0; i < len; i++) begin
                do c = 8'($urandom_range(255));
                while (c == C_DQUOTE || c == C_NEWLINE);
                queue_byte(c);
            end
            ending = $urandom_range(9);
            if (ending < 7) queue_byte(C_DQUOTE);
            else if (ending == 7) queue_byte(C_NEWLINE);
            else pending_bytes[pending_bytes.size() - 1].eof = 1'b1;
        end else if (kind < 60) begin
            // Block comment, sometimes a lone slash instead.
            queue_byte(C_SLASH);
            if ($urandom_range(4) == 0) begin
                queue_byte(8'($urandom_range(255)));
            end else begin
                queue_byte(C_STAR);
                len = $urandom_range(5);
                repeat (len) queue_byte($urandom_range(1) ? C_STAR : 8'($urandom_range(255)));
                len = $urandom_range(1, 3);
                repeat (len) queue_byte(C_STAR);
                queue_byte(C_SLASH);
            end
        end else if (kind < 76) begin
            // Character or string literal with escapes.
            quote = (kind < 68) ? C_SQUOTE : C_DQUOTE;
            queue_byte(quote);
            len = $urandom_range(5);
            for (int i = 0; i < len; i++) begin
                if ($urandom_range(3) == 0) begin
                    queue_byte(C_BACKSLASH);
                    queue_byte($urandom_range(1) ? quote : 8'($urandom_range(255)));
                end else begin
                    queue_byte(8'($urandom_range(255)));
                end
            end
            queue_byte(quote);
        end else if (kind < 92) begin
            len = $urandom_range(1, 4);
            repeat (len) queue_byte(8'($urandom_range(255)));
        end else begin
            queue_byte(C_NEWLINE);
        end
        if ($urandom_range(24) == 0) pending_bytes[pending_bytes.size() - 1].eof = 1'b1;
    endtask

    // Waits until every queued byte has gone in and every result has come out.
    task automatic wait_until_drained();
        while (bytes_accepted != bytes_queued || expected_results.size() != 0)
            @(posedge i_clk);
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: an empty name, then a name of the extreme byte cut off by
        // the end of the file on a zero byte.
        queue_text("#include\"\"");
        queue_text("#include\"");
        queue_byte(8'hFF);
        queue_byte(8'h00, 1'b1);

        // Sender mostly active, receiver mostly stalled.
        while (bytes_queued < 600) queue_random_fragment();
        wait_until_drained();

        // The other way round; the sender has paused until the block drained.
        sender_idle_pct   = 87;
        receiver_idle_pct = 27;
        while (bytes_queued < 1180) queue_random_fragment();
        wait_until_drained();

        // No idling. The receiver first holds off long enough that the block fills
        // up and stalls its input while the sender keeps offering bytes.
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        while (bytes_queued < 1750) queue_random_fragment();
        hold_requests = 1;
        wait_until_drained();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (failures == 0 && expected_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

### c_include_directive_scanner.f
hw/rtl/cids_pkg.sv
hw/rtl/c_include_directive_scanner.sv
tb/c_include_directive_scanner_test.sv
